// ===== design/mebcp_pkg.sv =====
// Shared types and codes for the mapped EPS bearer context parser.
`default_nettype none

package mebcp_pkg;

    // Field kinds reported per byte
    localparam logic [2:0] KIND_BEARER   = 3'd0;
    localparam logic [2:0] KIND_LEN_HI   = 3'd1;
    localparam logic [2:0] KIND_LEN_LO   = 3'd2;
    localparam logic [2:0] KIND_OP       = 3'd3;
    localparam logic [2:0] KIND_PAR_ID   = 3'd4;
    localparam logic [2:0] KIND_PAR_LEN  = 3'd5;
    localparam logic [2:0] KIND_CONTENT  = 3'd6;

    localparam logic [1:0] OP_RESERVED   = 2'd0;
    localparam logic [1:0] OP_CREATE     = 2'd1;
    localparam logic [1:0] OP_DELETE     = 2'd2;
    localparam logic [1:0] OP_MODIFY     = 2'd3;

    localparam logic [7:0] CTX_FIRST     = 8'd1;
    localparam logic [7:0] CTX_MAX       = 8'hff;

    typedef enum logic [6:0] {
        PH_BEARER  = 7'b0000001,
        PH_LEN_HI  = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_OP      = 7'b0001000,
        PH_PAR_ID  = 7'b0010000,
        PH_PAR_LEN = 7'b0100000,
        PH_CONTENT = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  context_number;
        logic [3:0]  parameter_number;
        logic [3:0]  bearer_identity;
        logic [15:0] context_length;
        logic [1:0]  operation_code;
        logic        e_bit;
        logic        e_bit_means_replacement;
        logic [3:0]  parameter_count;
        logic [7:0]  parameter_id;
        logic [7:0]  parameter_length;
        logic        truncated;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mapped_eps_bearer_context_parser.sv =====
// Byte classifier for the value part of a Mapped EPS bearer contexts element.
// One byte is taken per cycle while in_stall is low, and its classification
// appears in an output register in the following cycle; the only loop is the
// parse state update, which is a few small counters and a one-hot phase, so
// throughput is one request per clock while not stalled. in_stall rises only
// when the output register holds an untaken result and out_stall is high.
// first_of_element restarts parsing before its byte; last_of_element flags
// truncation when a structure is left open and then restarts parsing after its
// byte. Results carry zero in fields that do not apply to their field_kind.
`default_nettype none

module mapped_eps_bearer_context_parser
    import mebcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_of_element,
    input  wire logic        last_of_element,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       field_kind,
    output logic [7:0]       context_number,
    output logic [3:0]       parameter_number,
    output logic [3:0]       bearer_identity,
    output logic [15:0]      context_length,
    output logic [1:0]       operation_code,
    output logic             e_bit,
    output logic             e_bit_means_replacement,
    output logic [3:0]       parameter_count,
    output logic [7:0]       parameter_id,
    output logic [7:0]       parameter_length,
    output logic             truncated
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  ctx_reg, ctx_next;
    logic [3:0]  pnum_reg, pnum_next;
    logic [3:0]  pleft_reg, pleft_next;
    logic [7:0]  cleft_reg, cleft_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    phase_t      phase_cur;
    logic [7:0]  ctx_cur, ctx_inc;
    logic [3:0]  pnum_cur, pleft_cur, pleft_dec;
    logic [7:0]  cleft_cur, cleft_dec;
    logic [7:0]  lenhi_cur;
    logic        accept;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        // A new element discards whatever was left open
        phase_cur = first_of_element ? PH_BEARER : phase_reg;
        ctx_cur   = first_of_element ? CTX_FIRST : ctx_reg;
        pnum_cur  = first_of_element ? 4'd0 : pnum_reg;
        pleft_cur = first_of_element ? 4'd0 : pleft_reg;
        cleft_cur = first_of_element ? 8'd0 : cleft_reg;
        lenhi_cur = first_of_element ? 8'd0 : lenhi_reg;

        ctx_inc   = (ctx_cur != CTX_MAX) ? ctx_cur + 8'd1 : ctx_cur;
        pleft_dec = pleft_cur - 4'd1;
        cleft_dec = cleft_cur - 8'd1;

        phase_next = phase_cur;
        ctx_next   = ctx_cur;
        pnum_next  = pnum_cur;
        pleft_next = pleft_cur;
        cleft_next = cleft_cur;
        lenhi_next = lenhi_cur;

        res_next = '0;
        res_next.context_number = ctx_cur;

        unique case (phase_cur)
            PH_LEN_HI:
            begin
                res_next.field_kind = KIND_LEN_HI;
                lenhi_next = data_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                res_next.field_kind     = KIND_LEN_LO;
                res_next.context_length = {lenhi_cur, data_byte};
                phase_next = PH_OP;
            end
            PH_OP:
            begin
                res_next.field_kind              = KIND_OP;
                res_next.operation_code          = data_byte[7:6];
                res_next.e_bit                   = data_byte[4];
                res_next.e_bit_means_replacement = (data_byte[7:6] == OP_MODIFY);
                res_next.parameter_count         = data_byte[3:0];
                if (data_byte[3:0] != 4'd0)
                begin
                    pleft_next = data_byte[3:0];
                    pnum_next  = 4'd1;
                    phase_next = PH_PAR_ID;
                end
                else
                begin
                    ctx_next   = ctx_inc;
                    pnum_next  = 4'd0;
                    pleft_next = 4'd0;
                    phase_next = PH_BEARER;
                end
            end
            PH_PAR_ID:
            begin
                res_next.field_kind       = KIND_PAR_ID;
                res_next.parameter_number = pnum_cur;
                res_next.parameter_id     = data_byte;
                phase_next = PH_PAR_LEN;
            end
            PH_PAR_LEN, PH_CONTENT:
            begin
                res_next.parameter_number = pnum_cur;
                if (phase_cur == PH_PAR_LEN)
                begin
                    res_next.field_kind       = KIND_PAR_LEN;
                    res_next.parameter_length = data_byte;
                    cleft_next = data_byte;
                end
                else
                begin
                    res_next.field_kind = KIND_CONTENT;
                    cleft_next = cleft_dec;
                end
                // Parameter done: empty length, or last content byte
                if ((phase_cur == PH_PAR_LEN && data_byte == 8'd0) ||
                    (phase_cur == PH_CONTENT && cleft_dec == 8'd0))
                begin
                    if (pleft_dec != 4'd0)
                    begin
                        pleft_next = pleft_dec;
                        pnum_next  = pnum_cur + 4'd1;
                        phase_next = PH_PAR_ID;
                    end
                    else
                    begin
                        ctx_next   = ctx_inc;
                        pnum_next  = 4'd0;
                        pleft_next = 4'd0;
                        phase_next = PH_BEARER;
                    end
                end
                else if (phase_cur == PH_PAR_LEN)
                begin
                    phase_next = PH_CONTENT;
                end
            end
            default:
            begin
                res_next.field_kind      = KIND_BEARER;
                res_next.bearer_identity = data_byte[7:4];
                phase_next = PH_LEN_HI;
            end
        endcase

        if (last_of_element)
        begin
            res_next.truncated = (phase_next != PH_BEARER);
            phase_next = PH_BEARER;
            ctx_next   = CTX_FIRST;
            pnum_next  = 4'd0;
            pleft_next = 4'd0;
            cleft_next = 8'd0;
            lenhi_next = 8'd0;
        end

        out_valid_next = accept | in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEARER;
            ctx_reg       <= CTX_FIRST;
            pnum_reg      <= 4'd0;
            pleft_reg     <= 4'd0;
            cleft_reg     <= 8'd0;
            lenhi_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                ctx_reg   <= ctx_next;
                pnum_reg  <= pnum_next;
                pleft_reg <= pleft_next;
                cleft_reg <= cleft_next;
                lenhi_reg <= lenhi_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid               = out_valid_reg;
    assign field_kind              = res_reg.field_kind;
    assign context_number          = res_reg.context_number;
    assign parameter_number        = res_reg.parameter_number;
    assign bearer_identity         = res_reg.bearer_identity;
    assign context_length          = res_reg.context_length;
    assign operation_code          = res_reg.operation_code;
    assign e_bit                   = res_reg.e_bit;
    assign e_bit_means_replacement = res_reg.e_bit_means_replacement;
    assign parameter_count         = res_reg.parameter_count;
    assign parameter_id            = res_reg.parameter_id;
    assign parameter_length        = res_reg.parameter_length;
    assign truncated               = res_reg.truncated;

    // End of element always leaves the parser at a fresh context
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_of_element |=> phase_reg == PH_BEARER && ctx_reg == CTX_FIRST)
        else $error("parse state not restarted after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> context_number != 8'd0)
        else $error("context number is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (field_kind == KIND_PAR_ID || field_kind == KIND_PAR_LEN ||
                          field_kind == KIND_CONTENT) |-> parameter_number != 4'd0)
        else $error("parameter byte without parameter number");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && e_bit_means_replacement |->
            field_kind == KIND_OP && operation_code == OP_MODIFY)
        else $error("replacement flag outside a modify operation byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CONTENT |-> cleft_reg != 8'd0 && pleft_reg != 4'd0)
        else $error("content phase with nothing left to read");

endmodule

`default_nettype wire
